// File: src/mmwc_pkg.sv
// ----------------------------------------------------------------------------
// mmwc_pkg
// Shared types and constants for the median moisture watering controller.
// ----------------------------------------------------------------------------
package mmwc_pkg;

  localparam int MOIST_W = 10;
  localparam int TIME_W  = 32;
  localparam int BIT_W   = 4;
  localparam int IN_W    = 48;
  localparam int OUT_W   = 16;
  localparam int CFG_IW  = 3;

  // Input word layout.
  localparam int IN_NOW_LSB    = 0;
  localparam int IN_SAMPLE_LSB = 32;
  localparam int IN_GRANT_BIT  = 42;

  // Output word layout.
  localparam int OUT_NEEDS_BIT  = 0;
  localparam int OUT_VALID_BIT  = 1;
  localparam int OUT_MEDIAN_LSB = 2;
  localparam int OUT_POWER_BIT  = 12;
  localparam int OUT_VALVE_BIT  = 13;

  typedef enum logic [CFG_IW-1:0] {
    CFG_UPPER_THRESHOLD = 3'd0,
    CFG_LOWER_THRESHOLD = 3'd1,
    CFG_READ_INTERVAL   = 3'd2,
    CFG_REWATER_WAIT    = 3'd3,
    CFG_WATER_DURATION  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEL,
    ST_DEC,
    ST_DONE
  } state_t;

  localparam logic [MOIST_W-1:0] UPPER_RST    = 10'd600;
  localparam logic [MOIST_W-1:0] LOWER_RST    = 10'd400;
  localparam logic [TIME_W-1:0]  INTERVAL_RST = 32'd60000;
  localparam logic [TIME_W-1:0]  REWAIT_RST   = 32'd300000;
  localparam logic [TIME_W-1:0]  DURATION_RST = 32'd10000;

endpackage

// File: src/median_moisture_watering_control.sv
// ----------------------------------------------------------------------------
// median_moisture_watering_control
// Poll-driven watering controller: sample window, median, hysteresis rule.
// ----------------------------------------------------------------------------
// A poll that does not complete the window goes from ST_IDLE to ST_DONE, which
// registers its word and returns to ST_IDLE for the next poll.
// A poll that completes the window runs a bitwise radix select over the sample
// RAM in 10 sweeps (ST_SEL), then ST_DEC and ST_DONE; a discarded median skips
// ST_DEC. No new poll is taken until the word has been registered.
// rst_n is synchronous and active low; it loads the register reset values.
module median_moisture_watering_control #(
  parameter int WINDOW_SAMPLES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: now_ms[31:0], moisture_sample[41:32], start_watering[42], zeros
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mmwc_pkg::IN_W-1:0]       in_tdata,
  // out_tdata: needs_water[0], median_valid[1], median_value[11:2],
  //            sensor_power[12], valve_open[13], zeros
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mmwc_pkg::OUT_W-1:0]      out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mmwc_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [mmwc_pkg::TIME_W-1:0]     cfg_data
);
  import mmwc_pkg::*;

  localparam int AW = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
  localparam int CW = $clog2(WINDOW_SAMPLES + 1);
  localparam logic [AW-1:0] LAST_FILL = AW'(WINDOW_SAMPLES - 1);
  localparam logic [CW-1:0] SWEEP_END = CW'(WINDOW_SAMPLES);
  localparam logic [CW-1:0] RANK      = CW'(WINDOW_SAMPLES / 2);
  localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(MOIST_W - 1);

  state_t state_r, state_nxt;

  logic [MOIST_W-1:0] upper_r, upper_nxt;
  logic [MOIST_W-1:0] lower_r, lower_nxt;
  logic [TIME_W-1:0]  interval_r, interval_nxt;
  logic [TIME_W-1:0]  rewait_r, rewait_nxt;
  logic [TIME_W-1:0]  duration_r, duration_nxt;

  logic [AW-1:0]      fill_r, fill_nxt;
  logic [MOIST_W-1:0] median_r, median_nxt;
  logic               trig_r, trig_nxt;
  logic               queued_r, queued_nxt;
  logic               valve_r, valve_nxt;
  logic               idle_r, idle_nxt;
  logic               first_r, first_nxt;
  logic [TIME_W-1:0]  pot_r, pot_nxt;
  logic [TIME_W-1:0]  wst_r, wst_nxt;

  logic [TIME_W-1:0]  diff_r, diff_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic [MOIST_W-1:0] prefix_r, prefix_nxt;
  logic [CW-1:0]      rank_r, rank_nxt;
  logic [CW-1:0]      sweep_r, sweep_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               needs_r, needs_nxt;
  logic               valid_r, valid_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]   out_tdata_r, out_tdata_nxt;

  logic               ram_we;
  logic               ram_re;
  logic [MOIST_W-1:0] ram_rdata;

  logic [TIME_W-1:0]  in_now;
  logic [MOIST_W-1:0] in_sample;
  logic               in_grant;

  assign in_now    = in_tdata[IN_NOW_LSB +: TIME_W];
  assign in_sample = in_tdata[IN_SAMPLE_LSB +: MOIST_W];
  assign in_grant  = in_tdata[IN_GRANT_BIT];

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign cfg_ready  = 1'b1;
  assign ram_re     = (state_r == ST_SEL) && (sweep_r != SWEEP_END);

  mmwc_ram #(
    .WIDTH (MOIST_W),
    .DEPTH (WINDOW_SAMPLES)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r),
    .wdata (in_sample),
    .re    (ram_re),
    .raddr (sweep_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    logic               idle_v;
    logic [MOIST_W-1:0] bit_mask;
    logic [MOIST_W-1:0] hi_mask;
    logic               match;
    logic [CW-1:0]      cnt_tot;
    logic [MOIST_W-1:0] prefix_v;

    state_nxt      = state_r;
    upper_nxt      = upper_r;
    lower_nxt      = lower_r;
    interval_nxt   = interval_r;
    rewait_nxt     = rewait_r;
    duration_nxt   = duration_r;
    fill_nxt       = fill_r;
    median_nxt     = median_r;
    trig_nxt       = trig_r;
    queued_nxt     = queued_r;
    valve_nxt      = valve_r;
    idle_nxt       = idle_r;
    first_nxt      = first_r;
    pot_nxt        = pot_r;
    wst_nxt        = wst_r;
    diff_nxt       = diff_r;
    bit_nxt        = bit_r;
    prefix_nxt     = prefix_r;
    rank_nxt       = rank_r;
    sweep_nxt      = sweep_r;
    cnt_nxt        = cnt_r;
    needs_nxt      = needs_r;
    valid_nxt      = valid_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    ram_we         = 1'b0;

    idle_v   = idle_r;
    bit_mask = MOIST_W'(1) << bit_r;
    hi_mask  = ({MOIST_W{1'b1}} << bit_r) << 1;
    match    = (((ram_rdata ^ prefix_r) & hi_mask) == '0) && ((ram_rdata & bit_mask) == '0);
    cnt_tot  = cnt_r + CW'(match);
    prefix_v = prefix_r;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_UPPER_THRESHOLD: upper_nxt    = cfg_data[MOIST_W-1:0];
        CFG_LOWER_THRESHOLD: lower_nxt    = cfg_data[MOIST_W-1:0];
        CFG_READ_INTERVAL:   interval_nxt = cfg_data;
        CFG_REWATER_WAIT:    rewait_nxt   = cfg_data;
        CFG_WATER_DURATION:  duration_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          needs_nxt = 1'b0;
          valid_nxt = 1'b0;
          diff_nxt  = in_grant ? '0 : (in_now - wst_r);
          if (in_grant) begin
            valve_nxt  = 1'b1;
            queued_nxt = 1'b0;
            wst_nxt    = in_now;
          end
          if (idle_r && ((in_now - pot_r) > interval_r)) begin
            idle_v    = 1'b0;
            pot_nxt   = in_now;
            first_nxt = 1'b1;
          end
          idle_nxt  = idle_v;
          state_nxt = ST_DONE;
          if (!idle_v) begin
            ram_we = 1'b1;
            if (fill_r == LAST_FILL) begin
              fill_nxt   = '0;
              bit_nxt    = TOP_BIT;
              prefix_nxt = '0;
              rank_nxt   = RANK;
              sweep_nxt  = '0;
              cnt_nxt    = '0;
              state_nxt  = ST_SEL;
            end else begin
              fill_nxt = fill_r + AW'(1);
            end
          end
        end
      end

      // One sweep per median bit, from the top bit down: count the entries
      // that share the prefix found so far and have a zero in this bit.
      ST_SEL: begin
        sweep_nxt = sweep_r + CW'(1);
        if (sweep_r != '0) begin
          cnt_nxt = cnt_tot;
        end
        if (sweep_r == SWEEP_END) begin
          if (rank_r >= cnt_tot) begin
            prefix_v = prefix_r | bit_mask;
            rank_nxt = rank_r - cnt_tot;
          end
          prefix_nxt = prefix_v;
          sweep_nxt  = '0;
          cnt_nxt    = '0;
          if (bit_r == '0) begin
            median_nxt = prefix_v;
            if (first_r) begin
              first_nxt = 1'b0;
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_DEC;
            end
          end else begin
            bit_nxt = bit_r - BIT_W'(1);
          end
        end
      end

      ST_DEC: begin
        valid_nxt = 1'b1;
        state_nxt = ST_DONE;
        if (valve_r) begin
          if (diff_r > duration_r) begin
            valve_nxt = 1'b0;
          end
        end else if (queued_r) begin
          // A request is already pending.
        end else if ((median_r < lower_r) && trig_r) begin
          trig_nxt = 1'b0;
          idle_nxt = 1'b1;
        end else if ((median_r > lower_r) && trig_r && (diff_r > rewait_r)) begin
          queued_nxt = 1'b1;
          needs_nxt  = 1'b1;
        end else if ((median_r > upper_r) && !trig_r) begin
          trig_nxt   = 1'b1;
          queued_nxt = 1'b1;
          needs_nxt  = 1'b1;
        end else if ((median_r < lower_r) && !trig_r) begin
          idle_nxt = 1'b1;
        end
      end

      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {2'b00, valve_r, !idle_r, median_r, valid_r, needs_r};
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      upper_r      <= UPPER_RST;
      lower_r      <= LOWER_RST;
      interval_r   <= INTERVAL_RST;
      rewait_r     <= REWAIT_RST;
      duration_r   <= DURATION_RST;
      fill_r       <= '0;
      median_r     <= '0;
      trig_r       <= 1'b0;
      queued_r     <= 1'b0;
      valve_r      <= 1'b0;
      idle_r       <= 1'b0;
      first_r      <= 1'b1;
      pot_r        <= '0;
      wst_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      upper_r      <= upper_nxt;
      lower_r      <= lower_nxt;
      interval_r   <= interval_nxt;
      rewait_r     <= rewait_nxt;
      duration_r   <= duration_nxt;
      fill_r       <= fill_nxt;
      median_r     <= median_nxt;
      trig_r       <= trig_nxt;
      queued_r     <= queued_nxt;
      valve_r      <= valve_nxt;
      idle_r       <= idle_nxt;
      first_r      <= first_nxt;
      pot_r        <= pot_nxt;
      wst_r        <= wst_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r      <= diff_nxt;
    bit_r       <= bit_nxt;
    prefix_r    <= prefix_nxt;
    rank_r      <= rank_nxt;
    sweep_r     <= sweep_nxt;
    cnt_r       <= cnt_nxt;
    needs_r     <= needs_nxt;
    valid_r     <= valid_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule

// File: src/mmwc_ram.sv
// ----------------------------------------------------------------------------
// mmwc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mmwc_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/mmwc_chk.sv
// ----------------------------------------------------------------------------
// mmwc_chk
// Port-level checks for the median moisture watering controller.
// ----------------------------------------------------------------------------
module mmwc_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [mmwc_pkg::OUT_W-1:0] out_tdata
);
  import mmwc_pkg::*;

  // A word that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped before it was taken");

  // The block works on one poll at a time.
  a_one_poll: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("poll accepted while another is in progress");

  // A watering request only comes from a fresh median.
  a_need_median: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_NEEDS_BIT] |-> out_tdata[OUT_VALID_BIT])
    else $error("watering requested without a new median");

  // A watering request is never raised while the valve is open.
  a_need_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_NEEDS_BIT] |-> !out_tdata[OUT_VALVE_BIT])
    else $error("watering requested with the valve open");

  // The result side comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word offered right after reset");

endmodule

bind median_moisture_watering_control mmwc_chk u_mmwc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
